[rtl/core/mtin_pkg.sv]
// Package for the MAC to IP and node id table.
// Holds the entry and result types and the request, kind and status codes.
// No dependencies; every other file of the block imports it.
package mtin_pkg;

    // Field widths fixed by the request and result formats.
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 5;

    // A list transaction reports at most this many entries.
    localparam logic [COUNT_W-1:0] LIST_MAX = 5'd16;

    // Request codes.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_LIST  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;
    localparam logic [1:0] KIND_COUNT  = 2'd3;

    // Add status codes.
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // One table slot; an all-zero MAC marks a free slot.
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic [ID_W-1:0]  node_id;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         add_status;
        logic [ID_W-1:0]    found_id;
        logic [IP_W-1:0]    entry_ip;
        logic [MAC_W-1:0]   entry_mac;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_rsp;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

endpackage

[rtl/core/mtin_req_if.sv]
// Request channel of the MAC to IP and node id table.
// Carries valid, ready and the request fields; depends on mtin_pkg.
interface mtin_req_if
    import mtin_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip_addr;
    logic [ID_W-1:0]  node_id;

    modport source (output valid, req_type, mac, ip_addr, node_id, input ready);
    modport sink   (input valid, req_type, mac, ip_addr, node_id, output ready);
endinterface

[rtl/core/mtin_rsp_if.sv]
// Result channel of the MAC to IP and node id table.
// Carries valid, ready and the result fields; depends on mtin_pkg.
interface mtin_rsp_if
    import mtin_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         add_status;
    logic [ID_W-1:0]    found_id;
    logic [IP_W-1:0]    entry_ip;
    logic [MAC_W-1:0]   entry_mac;
    logic [COUNT_W-1:0] entry_count;
    logic               last;

    modport source (output valid, kind, add_status, found_id, entry_ip, entry_mac,
                    entry_count, last, input ready);
    modport sink   (input valid, kind, add_status, found_id, entry_ip, entry_mac,
                    entry_count, last, output ready);
endinterface

[rtl/core/mtin_cell.sv]
// One cell of the table ring: holds a single slot and passes it on when shifted.
// Depends on mtin_pkg.
module mtin_cell
    import mtin_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // The slot is cleared to free at reset and takes its neighbour's entry on a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[rtl/core/mtin_ctrl.sv]
// Request controller of the table: examines the slot at the head of the ring
// each step, writes the possibly updated slot back at the tail, and drives
// the output register. Depends on mtin_pkg, mtin_req_if and mtin_rsp_if.
module mtin_ctrl
    import mtin_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    output t_entry      o_tail,
    output logic        o_shift,
    mtin_req_if.sink    i_req,
    mtin_rsp_if.source  o_rsp
);

    localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);

    t_state             r_state,  n_state;
    logic [STEP_W-1:0]  r_step,   n_step;
    logic [1:0]         r_type,   n_type;
    logic [MAC_W-1:0]   r_mac,    n_mac;
    logic [IP_W-1:0]    r_ip,     n_ip;
    logic [ID_W-1:0]    r_id,     n_id;
    logic               r_done,   n_done;
    logic [1:0]         r_status, n_status;
    logic [ID_W-1:0]    r_fid,    n_fid;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out,    n_out;

    logic out_free;
    logic want_emit;
    logic emit;
    t_rsp emit_rsp;

    assign out_free = !r_out_valid || o_rsp.ready;

    // A listed entry is emitted when its id matches and the list is not yet full.
    assign want_emit = (r_type == REQ_LIST) && (r_count != LIST_MAX)
                       && (i_head.node_id == r_id);

    // State register and request context.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_step   <= n_step;
        r_type   <= n_type;
        r_mac    <= n_mac;
        r_ip     <= n_ip;
        r_id     <= n_id;
        r_done   <= n_done;
        r_status <= n_status;
        r_fid    <= n_fid;
        r_count  <= n_count;
        r_out    <= n_out;
    end

    // Next state, slot write-back and result generation.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_type      = r_type;
        n_mac       = r_mac;
        n_ip        = r_ip;
        n_id        = r_id;
        n_done      = r_done;
        n_status    = r_status;
        n_fid       = r_fid;
        n_count     = r_count;
        o_tail      = i_head;
        o_shift     = 1'b0;
        i_req.ready = 1'b0;
        emit        = 1'b0;
        emit_rsp    = '0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_type   = i_req.req_type;
                    n_mac    = i_req.mac;
                    n_ip     = i_req.ip_addr;
                    n_id     = i_req.node_id;
                    n_step   = '0;
                    n_done   = 1'b0;
                    n_status = ST_FULL;
                    n_fid    = '0;
                    n_count  = '0;
                    // The unused request code is taken and dropped.
                    if (i_req.req_type == REQ_ADD || i_req.req_type == REQ_QUERY
                        || i_req.req_type == REQ_LIST) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // The ring holds still while a listed entry waits for the output.
                if (!want_emit || out_free) begin
                    o_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        n_state = S_FINISH;
                    end
                    if (!r_done && r_type == REQ_ADD) begin
                        if (i_head.mac == r_mac) begin
                            o_tail.ip      = r_ip;
                            o_tail.node_id = r_id;
                            n_done         = 1'b1;
                            n_status       = ST_UPDATED;
                        end else if (i_head.mac == '0) begin
                            o_tail.mac     = r_mac;
                            o_tail.ip      = r_ip;
                            o_tail.node_id = r_id;
                            n_done         = 1'b1;
                            n_status       = ST_INSERTED;
                        end
                    end
                    if (!r_done && r_type == REQ_QUERY && i_head.mac == r_mac) begin
                        n_fid  = i_head.node_id;
                        n_done = 1'b1;
                    end
                    if (want_emit) begin
                        emit               = 1'b1;
                        emit_rsp.kind      = KIND_ENTRY;
                        emit_rsp.entry_ip  = i_head.ip;
                        emit_rsp.entry_mac = i_head.mac;
                        n_count            = r_count + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_rsp.last = 1'b1;
                    n_state       = S_IDLE;
                    case (r_type)
                        REQ_ADD: begin
                            emit_rsp.kind       = KIND_ADD;
                            emit_rsp.add_status = r_status;
                        end
                        REQ_QUERY: begin
                            emit_rsp.kind     = KIND_QUERY;
                            emit_rsp.found_id = r_fid;
                        end
                        default: begin
                            emit_rsp.kind        = KIND_COUNT;
                            emit_rsp.entry_count = r_count;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded on a new result, emptied when the receiver takes it.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out       = emit_rsp;
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.add_status  = r_out.add_status;
    assign o_rsp.found_id    = r_out.found_id;
    assign o_rsp.entry_ip    = r_out.entry_ip;
    assign o_rsp.entry_mac   = r_out.entry_mac;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.last        = r_out.last;

endmodule

[rtl/core/mac_to_ip_node_table_core.sv]
// Top level of the MAC to IP and node id table.
// Depends on mtin_pkg, mtin_req_if, mtin_rsp_if, mtin_cell and mtin_ctrl.
//
// Usage:
//   Requests arrive on i_req: add or update a MAC, query the node id of a
//   MAC, or list up to LIST_MAX entries with a given node id. Results leave
//   on o_rsp, one transaction per add or query and one per listed entry plus
//   a final count for a list; the last result of a request has last set.
//   The slots sit in a ring of TABLE_DEPTH cells. A request rotates the ring
//   once, one slot per cycle past the controller while no listed entry waits
//   for the output, so the table is back in slot order when the request ends.
//   Sequence: a request walks TABLE_DEPTH ring steps, then a finish step
//   loads its final result into the output register; only then does the
//   block return to idle and accept the next request, so it does not take
//   a new request before the last one is done. A request of unused type 3
//   is accepted and dropped.
//   Reset clears every slot to free; the block is ready to accept a request
//   as soon as reset is released.
//   When the receiver stalls, the result stays in the output register and
//   the ring halts at any slot that has another entry to report.
module mac_to_ip_node_table_core
    import mtin_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtin_req_if.sink   i_req,
    mtin_rsp_if.source o_rsp
);

    t_entry cell_out [TABLE_DEPTH];
    t_entry tail;
    logic   shift;

    // Ring of slot cells: each cell takes the entry of the cell above it, the
    // top cell takes the slot written back by the controller.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        t_entry cell_in;
        if (k == TABLE_DEPTH - 1) begin : g_top
            assign cell_in = tail;
        end else begin : g_mid
            assign cell_in = cell_out[k+1];
        end
        mtin_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry (cell_in),
            .o_entry (cell_out[k])
        );
    end

    // Controller works on the slot in the bottom cell.
    mtin_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (cell_out[0]),
        .o_tail  (tail),
        .o_shift (shift),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for mac_to_ip_node_table_core: directed and random requests.
// Depends on mtin_pkg, mtin_req_if, mtin_rsp_if and the core; predicts every result itself.
module tb_top;
    import mtin_pkg::*;

    localparam int DEPTH       = 16;
    localparam int POOL_SIZE   = 20;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtin_req_if req_bus ();
    mtin_rsp_if rsp_bus ();

    mac_to_ip_node_table_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Mirror of the slot table and the results it is owed.
    t_entry           node_slots [DEPTH];
    t_rsp             answers_due[$];
    logic [MAC_W-1:0] mac_pool   [POOL_SIZE];

    int  mismatches    = 0;
    int  cycles        = 0;
    bit  req_gaps_on   = 1'b1;
    bit  rsp_stalls_on = 1'b1;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    always #4 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[MAC_W-1:0];
    endfunction

    // Node ids cluster on a few values so that lists find several entries.
    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(0, 3));
        return ID_W'($urandom);
    endfunction

    // Mostly known addresses, sometimes a fresh one, rarely the free marker.
    function automatic logic [MAC_W-1:0] pick_mac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 95) return rand_mac();
        return '0;
    endfunction

    // Apply one accepted request to the mirror and queue the results it owes.
    function automatic void resolve_request(input logic [1:0] req_kind,
                                            input logic [MAC_W-1:0] mac,
                                            input logic [IP_W-1:0] ip,
                                            input logic [ID_W-1:0] id);
        t_rsp r;
        bit   done;
        int   n;
        r    = '0;
        done = 1'b0;
        n    = 0;
        case (req_kind)
            REQ_ADD: begin
                r.kind       = KIND_ADD;
                r.add_status = ST_FULL;
                for (int i = 0; i < DEPTH && !done; i++) begin
                    if (node_slots[i].mac == mac) begin
                        node_slots[i].ip      = ip;
                        node_slots[i].node_id = id;
                        r.add_status          = ST_UPDATED;
                        done                  = 1'b1;
                    end else if (node_slots[i].mac == '0) begin
                        node_slots[i] = '{mac: mac, ip: ip, node_id: id};
                        r.add_status  = ST_INSERTED;
                        done          = 1'b1;
                    end
                end
                r.last = 1'b1;
                answers_due.push_back(r);
            end
            REQ_QUERY: begin
                r.kind = KIND_QUERY;
                for (int i = 0; i < DEPTH && !done; i++) begin
                    if (node_slots[i].mac == mac) begin
                        r.found_id = node_slots[i].node_id;
                        done       = 1'b1;
                    end
                end
                r.last = 1'b1;
                answers_due.push_back(r);
            end
            REQ_LIST: begin
                for (int i = 0; i < DEPTH && n < int'(LIST_MAX); i++) begin
                    if (node_slots[i].node_id == id) begin
                        r           = '0;
                        r.kind      = KIND_ENTRY;
                        r.entry_ip  = node_slots[i].ip;
                        r.entry_mac = node_slots[i].mac;
                        answers_due.push_back(r);
                        n++;
                    end
                end
                r             = '0;
                r.kind        = KIND_COUNT;
                r.entry_count = COUNT_W'(n);
                r.last        = 1'b1;
                answers_due.push_back(r);
            end
            default: begin
                // The unused request type is dropped without a result.
            end
        endcase
    endfunction

    // Offer one request and wait for its transaction; valid stays high for a follow-on.
    task automatic offer_request(input logic [1:0] req_kind, input logic [MAC_W-1:0] mac,
                                 input logic [IP_W-1:0] ip, input logic [ID_W-1:0] id);
        int gap;
        gap = req_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= req_kind;
        req_bus.mac      <= mac;
        req_bus.ip_addr  <= ip;
        req_bus.node_id  <= id;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        resolve_request(req_kind, mac, ip, id);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Receiver: random stalls, mostly short, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left == 0 && stall_left == 0 && rsp_stalls_on && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.kind, rsp_bus.add_status, rsp_bus.found_id, rsp_bus.entry_ip,
                   rsp_bus.entry_mac, rsp_bus.entry_count, rsp_bus.last};
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", 64'(got.kind), 64'(got.last));
            end else begin
                want = answers_due.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.add_status !== want.add_status)
                    report_mismatch("add_status", 64'(got.add_status), 64'(want.add_status));
                if (got.found_id !== want.found_id)
                    report_mismatch("found_id", 64'(got.found_id), 64'(want.found_id));
                if (got.entry_ip !== want.entry_ip)
                    report_mismatch("entry_ip", 64'(got.entry_ip), 64'(want.entry_ip));
                if (got.entry_mac !== want.entry_mac)
                    report_mismatch("entry_mac", 64'(got.entry_mac), 64'(want.entry_mac));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
                if (got.last !== want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results still owed", answers_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // A cleared table: queries miss, a list of id zero reports every free slot.
    task automatic test_empty_table();
        offer_request(REQ_QUERY, mac_pool[0], '0, '0);
        offer_request(REQ_LIST, '0, '0, 8'd0);
        offer_request(REQ_LIST, '0, '0, 8'hFF);
        offer_request(2'd3, '1, '1, '1);
    endtask

    // Insert, update and read back, with the fields at their extremes.
    task automatic test_add_update();
        offer_request(REQ_ADD, mac_pool[0], 32'hFFFF_FFFF, 8'hFF);
        offer_request(REQ_ADD, mac_pool[0], 32'h0000_0000, 8'h01);
        offer_request(REQ_QUERY, mac_pool[0], '0, '0);
        offer_request(REQ_ADD, mac_pool[1], 32'h8000_0001, 8'hFF);
        offer_request(REQ_QUERY, 48'h0000_0000_0002, '1, '1);
        offer_request(REQ_LIST, '0, '0, 8'h01);
        offer_request(REQ_LIST, '0, '0, 8'hFF);
    endtask

    // An all-zero address lands on the first free slot without taking it.
    task automatic test_zero_mac();
        offer_request(REQ_ADD, '0, 32'hA5A5_A5A5, 8'h07);
        offer_request(REQ_QUERY, '0, '0, '0);
        offer_request(REQ_LIST, '0, '0, 8'h07);
        offer_request(REQ_ADD, '0, '0, 8'h00);
    endtask

    // Output held off for a long stretch while requests keep coming.
    task automatic test_long_hold();
        req_gaps_on  = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0) offer_request(REQ_LIST, '0, '0, rand_id());
            else if (i % 3 == 1) offer_request(REQ_QUERY, pick_mac(), $urandom, '0);
            else offer_request(REQ_ADD, pick_mac(), $urandom, rand_id());
        end
        req_gaps_on = 1'b1;
    endtask

    // Random mix of requests, with idling switched on and off in stretches.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0) begin
                req_gaps_on   = ($urandom_range(0, 3) != 0);
                rsp_stalls_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                offer_request(REQ_ADD, pick_mac(), $urandom, rand_id());
                sent++;
            end else if (pick < 70) begin
                offer_request(REQ_QUERY, pick_mac(), $urandom, ID_W'($urandom));
                sent++;
            end else if (pick < 95) begin
                offer_request(REQ_LIST, rand_mac(), $urandom, rand_id());
                sent++;
            end else begin
                offer_request(2'd3, rand_mac(), $urandom, ID_W'($urandom));
            end
        end
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
    endtask

    // Sender goes quiet until every owed result has been delivered.
    task automatic test_drain_pause();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        offer_request(REQ_LIST, '0, '0, rand_id());
        offer_request(REQ_QUERY, pick_mac(), '0, '0);
        offer_request(REQ_ADD, pick_mac(), $urandom, rand_id());
    endtask

    // Fill any remaining free slots, then show that a further add is refused.
    task automatic test_table_full();
        for (int i = 0; i < DEPTH + 2; i++) begin
            offer_request(REQ_ADD, rand_mac(), $urandom, rand_id());
            if (answers_due[$].add_status == ST_FULL) break;
        end
        offer_request(REQ_ADD, '0, 32'h1234_5678, 8'h05);
        offer_request(REQ_QUERY, '0, '0, '0);
        offer_request(REQ_LIST, '0, '0, 8'h00);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_ADD;
        req_bus.mac      = '0;
        req_bus.ip_addr  = '0;
        req_bus.node_id  = '0;
        rsp_bus.ready    = 1'b0;
        for (int i = 0; i < DEPTH; i++) node_slots[i] = '0;
        mac_pool[0] = 48'hFFFF_FFFF_FFFF;
        mac_pool[1] = 48'h0000_0000_0001;
        mac_pool[2] = 48'h8000_0000_0000;
        for (int i = 3; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_add_update();
        test_zero_mac();
        test_long_hold();
        test_random_traffic(170);
        test_drain_pause();
        test_random_traffic(120);
        test_table_full();
        test_random_traffic(40);

        // Let the last results drain, then allow for any trailing activity.
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
